// ===== rtl/core/sobel_pkg.sv =====
// ----------------------------------------------------------------------------
// sobel_pkg: shared types and constants of the Sobel edge magnitude block
// Holds register indexes, mode codes, the controller state type and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package sobel_pkg;

  // default line store depth
  localparam int SOBEL_MAX_WIDTH = 1024;

  // fixed geometry and field widths
  localparam int MAX_HEIGHT = 4096;
  localparam int HW         = 13;   // effective height width
  localparam int RW         = 12;   // row counter width
  localparam int COL_W      = 10;   // out_col width
  localparam int CFG_W      = 13;   // widest register
  localparam int IDX_W      = 2;

  // square root datapath widths
  localparam int GRAD_W = 10;
  localparam int SQ_W   = 21;
  localparam int RT_W   = 22;
  localparam int RT_STEPS = 11;

  localparam logic [7:0] SAT_MAX = 8'd255;

  // register indexes
  localparam logic [IDX_W-1:0] REG_EDGE_MODE    = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // edge mode codes
  localparam logic [1:0] MODE_MAG = 2'd0;
  localparam logic [1:0] MODE_H   = 2'd1;
  localparam logic [1:0] MODE_V   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQH,
    ST_SQV,
    ST_ROOT,
    ST_EMIT
  } sobel_state_t;

  typedef struct packed {
    logic accept;
    logic grad;
    logic sq_h;
    logic sq_v;
    logic root_step;
    logic emit;
  } sobel_cmd_t;

  typedef struct packed {
    logic interior;
    logic mag_mode;
    logic root_last;
    logic out_free;
  } sobel_status_t;

endpackage

// ===== rtl/core/sobel_ctrl.sv =====
// ----------------------------------------------------------------------------
// sobel_ctrl: sequencer of the Sobel edge magnitude block
// Read, gradient, then for interior pixels squares, root (magnitude) and emit.
// ----------------------------------------------------------------------------
module sobel_ctrl import sobel_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  sobel_status_t status,
  output sobel_cmd_t    cmd
);

  sobel_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.grad = 1'b1;
        if (!status.interior) begin
          state_next = ST_IDLE;
        end else if (status.mag_mode) begin
          state_next = ST_SQH;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_SQH: begin
        cmd.sq_h   = 1'b1;
        state_next = ST_SQV;
      end
      ST_SQV: begin
        cmd.sq_v   = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/sobel_dp.sv =====
// ----------------------------------------------------------------------------
// sobel_dp: datapath of the Sobel edge magnitude block
// Line stores, 3x3 window, raster counters, gradients, bit-pair square root
// and the output register.
// ----------------------------------------------------------------------------
module sobel_dp import sobel_pkg::*; #(
  parameter  int MAX_WIDTH = SOBEL_MAX_WIDTH,
  localparam int CW        = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1,
  localparam int WW        = (CW + 1 > 11) ? CW + 1 : 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sobel_cmd_t               cmd,
  output sobel_status_t            status,
  input  logic [1:0]               edge_mode,
  input  logic [WW-1:0]            w_eff,
  input  logic [HW-1:0]            h_eff,
  input  logic [7:0]               pixel,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               edge_value,
  output logic [COL_W-1:0]         out_col,
  output logic [RW-1:0]            out_row,
  output logic                     frame_last
);

  // line stores, no reset
  logic [7:0] mem_a [MAX_WIDTH];
  logic [7:0] mem_b [MAX_WIDTH];
  logic [7:0] mid, top, bot;

  logic [7:0] win [6];
  logic [CW-1:0] col;
  logic [RW-1:0] row;

  logic [GRAD_W-1:0] gh, gv;
  logic [SQ_W-1:0]   rem;
  logic [RT_W-1:0]   root, rbit;
  logic              res_mag;
  logic [COL_W-1:0]  res_col;
  logic [RW-1:0]     res_row;
  logic              res_last;

  // read port: issue at accept, data registered
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mid <= mem_a[col];
      top <= mem_b[col];
      bot <= pixel;
    end
    if (cmd.grad) begin
      mem_a[col] <= bot;
      mem_b[col] <= mid;
    end
  end

  // gradient terms
  logic [GRAD_W-1:0] sum_r, sum_l, sum_b, sum_t;
  logic [GRAD_W-1:0] gh_next, gv_next;
  logic              interior;
  logic [WW-1:0]     col_w, col_plus;
  logic [HW-1:0]     row_h, row_plus;
  logic [CW-1:0]     col_m1;
  logic [RW-1:0]     row_m1;

  always_comb begin
    sum_r = GRAD_W'(top) + (GRAD_W'(mid) << 1) + GRAD_W'(bot);
    sum_l = GRAD_W'(win[0]) + (GRAD_W'(win[1]) << 1) + GRAD_W'(win[2]);
    sum_b = GRAD_W'(win[2]) + (GRAD_W'(win[5]) << 1) + GRAD_W'(bot);
    sum_t = GRAD_W'(win[0]) + (GRAD_W'(win[3]) << 1) + GRAD_W'(top);
    gh_next = (sum_r >= sum_l) ? sum_r - sum_l : sum_l - sum_r;
    gv_next = (sum_b >= sum_t) ? sum_b - sum_t : sum_t - sum_b;
    col_w    = WW'(col);
    col_plus = col_w + WW'(1);
    row_h    = HW'(row);
    row_plus = row_h + HW'(1);
    col_m1   = col - CW'(1);
    row_m1   = row - RW'(1);
    interior = (row >= RW'(2)) && (col_w >= WW'(2));
  end

  // window, counters and result tags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
      col <= '0;
      row <= '0;
    end else if (cmd.grad) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= bot;
      if (col_plus >= w_eff) begin
        col <= '0;
        row <= (row_plus >= h_eff) ? '0 : RW'(row_plus);
      end else begin
        col <= CW'(col_plus);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      gh       <= gh_next;
      gv       <= gv_next;
      res_col  <= COL_W'(col_m1);
      res_row  <= row_m1;
      res_last <= (row_h == h_eff - HW'(1)) && (col_w == w_eff - WW'(1));
      res_mag  <= (edge_mode != MODE_H) && (edge_mode != MODE_V);
    end
  end

  // squares, then one bit pair of the root per cycle
  logic [RT_W-1:0] trial;
  always_comb begin
    trial = root + rbit;
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_h) begin
      rem <= SQ_W'(gh * gh);
    end else if (cmd.sq_v) begin
      rem  <= rem + SQ_W'(gv * gv);
      root <= '0;
      rbit <= RT_W'(1) << (2 * (RT_STEPS - 1));
    end else if (cmd.root_step) begin
      if (RT_W'(rem) >= trial) begin
        rem  <= rem - SQ_W'(trial);
        root <= (root >> 1) + rbit;
      end else begin
        root <= root >> 1;
      end
      rbit <= rbit >> 2;
    end
  end

  // scale, saturate, select
  logic [RT_W-1:0] sel, scaled;
  always_comb begin
    if (res_mag) begin
      sel = root;
    end else if (edge_mode == MODE_V) begin
      sel = RT_W'(gv);
    end else begin
      sel = RT_W'(gh);
    end
    scaled = sel >> 2;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      edge_value <= (|scaled[RT_W-1:8]) ? SAT_MAX : scaled[7:0];
      out_col    <= res_col;
      out_row    <= res_row;
      frame_last <= res_last;
    end
  end

  always_comb begin
    status.interior  = interior;
    status.mag_mode  = (edge_mode != MODE_H) && (edge_mode != MODE_V);
    status.root_last = rbit[0];
    status.out_free  = !out_valid || !out_stall;
  end

endmodule

// ===== rtl/core/sobel_edge_magnitude_top.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_top: 3x3 Sobel edge strength over a raster pixel stream
// Configuration registers, geometry clamping and the controller/datapath pair.
// ----------------------------------------------------------------------------
// Feed 8-bit pixels in raster order; each interior pixel yields one result
// tagged with the column and row of its window centre, and frame_last marks
// the last one of the frame. Pixels are handled one at a time by a sequencer:
// a border pixel passes through the idle and read states only, an interior
// pixel in horizontal or vertical mode through idle, read and emit, and in
// magnitude mode also through squaring of gh and gv and the square root,
// which resolves one bit pair of the 11-bit root per cycle. A stalled result
// holds the next interior pixel in its output step until the result leaves.
// The line stores are read and written through one registered port each.
// Write the registers only while no pixel is in flight; width is clamped to
// 3..MAX_WIDTH and height to 3..4096.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_top import sobel_pkg::*; #(
  parameter int MAX_WIDTH = SOBEL_MAX_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        edge_value,
  output logic [COL_W-1:0]  out_col,
  output logic [RW-1:0]     out_row,
  output logic              frame_last
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;

  logic [1:0]    edge_mode;
  logic [10:0]   image_width;
  logic [HW-1:0] image_height;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_mode    <= MODE_MAG;
      image_width  <= 11'd640;
      image_height <= 13'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EDGE_MODE:    edge_mode    <= cfg_data[1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HW-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp geometry
  always_comb begin
    if (WW'(image_width) < WW'(3)) begin
      w_eff = WW'(3);
    end else if (WW'(image_width) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height < HW'(3)) begin
      h_eff = HW'(3);
    end else if (image_height > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  sobel_cmd_t    cmd;
  sobel_status_t status;

  sobel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sobel_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .edge_mode  (edge_mode),
    .w_eff      (w_eff),
    .h_eff      (h_eff),
    .pixel      (pixel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .edge_value (edge_value),
    .out_col    (out_col),
    .out_row    (out_row),
    .frame_last (frame_last)
  );

  // busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("pixel accepted while previous pixel in flight");

  // never overwrite a result that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

  // results belong to interior rows only
  a_row_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_row != '0))
    else $error("result tagged with border row");

endmodule
